FILE: rtl/core/ppt_pkg.sv
// Shared types, constants and table builders for the piecewise power tone mapper.
package ppt_pkg;

    // Pipeline depth from accepted request to result strobe
    localparam int PIPE_DEPTH = 14;

    // Lookup tables are sized for the largest table setting (1024 cells plus end point)
    localparam int TAB_AW   = 11;
    localparam int TAB_LAST = 1024;

    // Configuration register indexes
    localparam logic [2:0] REG_INPUT_GAIN     = 3'd0;
    localparam logic [2:0] REG_SEGMENT_BOUNDS = 3'd1;
    localparam logic [2:0] REG_TOE_CURVE      = 3'd2;
    localparam logic [2:0] REG_TOE_PLACE      = 3'd3;
    localparam logic [2:0] REG_MID_CURVE      = 3'd4;
    localparam logic [2:0] REG_MID_PLACE      = 3'd5;
    localparam logic [2:0] REG_SHOULDER_CURVE = 3'd6;
    localparam logic [2:0] REG_SHOULDER_PLACE = 3'd7;

    localparam logic [23:0] GAIN_RESET = 24'd65536;

    typedef logic [31:0] ppt_tab_t [0:TAB_LAST];

    typedef struct packed {
        logic [23:0] red_in;
        logic [23:0] green_in;
        logic [23:0] blue_in;
        logic [15:0] alpha_in;
    } ppt_pixel_in_t;

    typedef struct packed {
        logic [17:0] red_out;
        logic [17:0] green_out;
        logic [17:0] blue_out;
        logic [15:0] alpha_out;
    } ppt_pixel_out_t;

    typedef struct packed {
        logic [23:0] input_gain;
        logic [31:0] segment_bounds;
        logic [63:0] toe_curve;
        logic [63:0] toe_place;
        logic [63:0] mid_curve;
        logic [63:0] mid_place;
        logic [63:0] shoulder_curve;
        logic [63:0] shoulder_place;
    } ppt_cfg_t;

    function automatic logic [63:0] ppt_isqrt(input logic [63:0] v);
        logic [63:0] rem_v;
        logic [63:0] r;
        logic [63:0] bit_v;
        rem_v = v;
        r     = 64'd0;
        bit_v = 64'd1 << 62;
        while (bit_v > rem_v)
            bit_v = bit_v >> 2;
        while (bit_v != 64'd0)
        begin
            if (rem_v >= r + bit_v)
            begin
                rem_v = rem_v - (r + bit_v);
                r     = (r >> 1) + bit_v;
            end
            else
            begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    // log2(1 + i/2^t) in Q0.30 by repeated squaring; end point exactly 1.0
    function automatic ppt_tab_t ppt_lg_table(input int t);
        ppt_tab_t    tab;
        logic [63:0] x;
        logic [63:0] r;
        for (int i = 0; i <= TAB_LAST; i++)
            tab[i] = 32'd0;
        for (int i = 0; i < (1 << t); i++)
        begin
            x = (64'd1 << 30) + (64'(i) << (30 - t));
            r = 64'd0;
            for (int k = 1; k <= 30; k++)
            begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30))
                begin
                    x = x >> 1;
                    r = r | (64'd1 << (30 - k));
                end
            end
            tab[i] = r[31:0];
        end
        tab[1 << t] = 32'd1 << 30;
        return tab;
    endfunction

    // 2^(i/2^t) in Q1.30 as products of repeated square roots; end point exactly 2.0
    function automatic ppt_tab_t ppt_ex_table(input int t);
        ppt_tab_t    tab;
        logic [63:0] roots [0:10];
        logic [63:0] prod;
        for (int i = 0; i <= TAB_LAST; i++)
            tab[i] = 32'd0;
        for (int k = 0; k <= 10; k++)
            roots[k] = 64'd0;
        roots[0] = 64'd2 << 30;
        for (int k = 1; k <= t; k++)
            roots[k] = ppt_isqrt(roots[k - 1] << 30);
        for (int i = 0; i < (1 << t); i++)
        begin
            prod = 64'd1 << 30;
            for (int k = 1; k <= t; k++)
                if (((i >> (t - k)) & 1) != 0)
                    prod = (prod * roots[k]) >> 30;
            tab[i] = prod[31:0];
        end
        tab[1 << t] = 32'd2 << 30;
        return tab;
    endfunction

endpackage

FILE: rtl/core/ppt_channel.sv
// One colour channel of the tone mapper: gain, segment pick, log2, power, exp2, scale.
module ppt_channel #(
    parameter int FRAC_BITS      = 16,
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic              clk,
    input  ppt_pkg::ppt_cfg_t cfg,
    input  logic [23:0]       chan_in,
    output logic [17:0]       chan_out
);
    import ppt_pkg::*;

    localparam int NORM_W = 16 + FRAC_BITS;
    localparam int DW     = 32 + FRAC_BITS;
    localparam int PW     = $clog2(DW);
    localparam int T      = LOG_TABLE_BITS;
    localparam int ER_W   = 24 - LOG_TABLE_BITS;
    localparam int SEG_N  = 11;

    localparam ppt_tab_t LG_TAB = ppt_lg_table(LOG_TABLE_BITS);
    localparam ppt_tab_t EX_TAB = ppt_ex_table(LOG_TABLE_BITS);

    typedef struct packed {
        logic signed [31:0] la;
        logic [31:0]        b;
        logic signed [20:0] scale;
        logic [20:0]        offy;
        logic               pos;
    } seg_t;

    // Stage 1: gain
    logic [47:0]       gain_prod;
    logic [NORM_W-1:0] norm_reg;

    // Stage 2: segment pick and offset
    logic [DW-1:0]     norm_ext, lo_ext, hi_ext, offx_ext;
    logic signed [DW:0] diff;
    logic [63:0]       curve_sel, place_sel;
    logic              is_toe, is_mid;
    logic [DW-1:0]     d_reg;
    seg_t              seg_next;
    seg_t              seg_reg [SEG_N];

    // Stage 3 .. 7: log2
    logic [PW-1:0]     p_next;
    logic [PW-1:0]     p3_reg, p4_reg, p5_reg, p6_reg;
    logic [DW-1:0]     d3_reg;
    logic [DW-1:0]     dn;
    logic [T-1:0]      idx_reg;
    logic [29:0]       rem4_reg, rem5_reg;
    logic [30:0]       lga_reg, lgd_reg;
    logic [60:0]       lg_mul;
    logic [30:0]       interp_reg;
    logic signed [31:0] lg_next, lg_reg;

    // Stage 8 .. 12: power and exp2
    logic signed [64:0] bl_full;
    logic signed [63:0] bl_reg;
    logic signed [40:0] z_reg;
    logic [T-1:0]      eidx;
    logic signed [16:0] zi_reg, zi11_reg;
    logic [31:0]       exa_reg, exd_reg;
    logic [ER_W-1:0]   erem_reg;
    logic [31+ER_W:0]  ex_mul;
    logic [31:0]       mant_reg;
    logic signed [16:0] zi_neg;
    logic [53:0]       y_next, y_reg;

    // Stage 13 .. 14: output scale and clamp
    logic [20:0]       smag;
    logic [42:0]       hi_reg;
    logic [52:0]       lo_reg;
    logic              neg_reg;
    logic [20:0]       offy_reg;
    logic [45:0]       mag;
    logic signed [47:0] outv;
    logic [17:0]       res_reg;

    always_comb
    begin
        gain_prod = 48'(chan_in) * 48'(cfg.input_gain);
    end

    always_comb
    begin
        norm_ext = {norm_reg, 16'b0};
        lo_ext   = DW'(cfg.segment_bounds[15:0]) << FRAC_BITS;
        hi_ext   = DW'(cfg.segment_bounds[31:16]) << FRAC_BITS;
        is_toe   = norm_ext < lo_ext;
        is_mid   = norm_ext < hi_ext;
        if (is_toe)
        begin
            curve_sel = cfg.toe_curve;
            place_sel = cfg.toe_place;
        end
        else if (is_mid)
        begin
            curve_sel = cfg.mid_curve;
            place_sel = cfg.mid_place;
        end
        else
        begin
            curve_sel = cfg.shoulder_curve;
            place_sel = cfg.shoulder_place;
        end
        offx_ext = DW'(place_sel[20:0]) << FRAC_BITS;
        diff     = $signed({1'b0, norm_ext}) - $signed({1'b0, offx_ext});
        // shoulder runs on the mirrored offset
        if (!is_toe && !is_mid)
            diff = -diff;
        seg_next.la    = $signed(curve_sel[63:32]);
        seg_next.b     = curve_sel[31:0];
        seg_next.scale = $signed(place_sel[62:42]);
        seg_next.offy  = place_sel[41:21];
        seg_next.pos   = !diff[DW] && (diff != '0);
    end

    // leading one of the offset input
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < DW; i++)
            if (d_reg[i])
                p_next = PW'(i);
    end

    always_comb
    begin
        dn     = d3_reg << (PW'(DW - 1) - p3_reg);
        lg_mul = 61'(lgd_reg) * 61'(rem5_reg);
        lg_next = ((32'(p6_reg) - 32'(FRAC_BITS + 16)) <<< 24)
                + $signed(32'(interp_reg[30:6]));
        bl_full = $signed({1'b0, seg_reg[5].b}) * lg_reg;
        eidx    = z_reg[23 -: T];
        ex_mul  = (32 + ER_W)'(exd_reg) * (32 + ER_W)'(erem_reg);
    end

    always_comb
    begin
        zi_neg = -zi11_reg;
        if (!seg_reg[9].pos)
            y_next = '0;
        else if (zi11_reg >= 17'sd23)
            y_next = 54'd1 << 53;
        else if (zi11_reg >= 17'sd0)
            y_next = 54'(mant_reg) << zi11_reg[4:0];
        else if (zi11_reg <= -17'sd63)
            y_next = '0;
        else
            y_next = 54'(mant_reg >> zi_neg[5:0]);
    end

    always_comb
    begin
        smag = seg_reg[10].scale[20] ? 21'(-seg_reg[10].scale) : seg_reg[10].scale;
        if (neg_reg)
            mag = (46'(hi_reg) << 2) + 46'((54'(lo_reg) + 54'((64'd1 << 30) - 1)) >> 30);
        else
            mag = (46'(hi_reg) << 2) + 46'(lo_reg >> 30);
        outv = (neg_reg ? -$signed(48'(mag)) : $signed(48'(mag)))
             + $signed(48'(offy_reg));
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= gain_prod[47:32-FRAC_BITS];

        d_reg      <= diff[DW-1:0];
        seg_reg[0] <= seg_next;
        for (int k = 1; k < SEG_N; k++)
            seg_reg[k] <= seg_reg[k - 1];

        p3_reg <= p_next;
        d3_reg <= d_reg;

        idx_reg  <= dn[DW-2 -: T];
        rem4_reg <= dn[DW-2-T -: 30];
        p4_reg   <= p3_reg;

        lga_reg  <= LG_TAB[TAB_AW'(idx_reg)][30:0];
        lgd_reg  <= LG_TAB[TAB_AW'(idx_reg) + TAB_AW'(1)][30:0]
                  - LG_TAB[TAB_AW'(idx_reg)][30:0];
        rem5_reg <= rem4_reg;
        p5_reg   <= p4_reg;

        interp_reg <= lga_reg + lg_mul[60:30];
        p6_reg     <= p5_reg;

        lg_reg <= lg_next;
        bl_reg <= bl_full[63:0];
        z_reg  <= 41'(seg_reg[6].la) + 41'($signed(bl_reg[63:24]));

        exa_reg  <= EX_TAB[TAB_AW'(eidx)];
        exd_reg  <= EX_TAB[TAB_AW'(eidx) + TAB_AW'(1)] - EX_TAB[TAB_AW'(eidx)];
        erem_reg <= z_reg[ER_W-1:0];
        zi_reg   <= z_reg[40:24];

        mant_reg <= exa_reg + 32'(ex_mul >> ER_W);
        zi11_reg <= zi_reg;

        y_reg <= y_next;

        hi_reg   <= 43'(y_reg[53:32]) * 43'(smag);
        lo_reg   <= 53'(y_reg[31:0]) * 53'(smag);
        neg_reg  <= seg_reg[10].scale[20];
        offy_reg <= seg_reg[10].offy;

        if (outv < 48'sd0)
            res_reg <= '0;
        else if (outv > 48'sd262143)
            res_reg <= '1;
        else
            res_reg <= outv[17:0];
    end

    assign chan_out = res_reg;

endmodule

FILE: rtl/core/piecewise_power_tonemap.sv
// Top level of the piecewise power-curve filmic tone mapper.
//
// Takes one RGBA pixel request on every clock at which start is high (busy stays
// low: the pipeline never stops) and shows the mapped pixel on result for one
// cycle, marked by done, once it leaves the pipeline. Results cannot be held off, so
// the downstream side must take every strobe. The latency is set by the 14-stage
// pipeline of each colour channel: gain, segment pick, leading-one search,
// normalise, log2 table read, interpolation, log2 assembly, exponent multiply,
// power sum, exp2 table read, exp2 interpolation, power shift, output scale and
// clamp. Write the configuration registers only while no request is in flight;
// they are read by the pipeline directly. Alpha travels alongside unchanged.
module piecewise_power_tonemap #(
    parameter int FRAC_BITS      = 16,
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  ppt_pkg::ppt_pixel_in_t  pixel,
    output logic                   done,
    output ppt_pkg::ppt_pixel_out_t result,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data
);
    import ppt_pkg::*;

    ppt_cfg_t          cfg_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [15:0]       alpha_reg [PIPE_DEPTH];
    logic              accept;

    // never hold off a request
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{input_gain: GAIN_RESET, default: '0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INPUT_GAIN:     cfg_reg.input_gain     <= cfg_data[23:0];
                REG_SEGMENT_BOUNDS: cfg_reg.segment_bounds <= cfg_data[31:0];
                REG_TOE_CURVE:      cfg_reg.toe_curve      <= cfg_data;
                REG_TOE_PLACE:      cfg_reg.toe_place      <= cfg_data;
                REG_MID_CURVE:      cfg_reg.mid_curve      <= cfg_data;
                REG_MID_PLACE:      cfg_reg.mid_place      <= cfg_data;
                REG_SHOULDER_CURVE: cfg_reg.shoulder_curve <= cfg_data;
                REG_SHOULDER_PLACE: cfg_reg.shoulder_place <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // advance the valid bits alongside the channel stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], accept};
    end

    // hold alpha in a delay line matching the channel latency
    always_ff @(posedge clk)
    begin
        alpha_reg[0] <= pixel.alpha_in;
        for (int k = 1; k < PIPE_DEPTH; k++)
            alpha_reg[k] <= alpha_reg[k - 1];
    end

    ppt_channel #(
        .FRAC_BITS      (FRAC_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_red (
        .clk      (clk),
        .cfg      (cfg_reg),
        .chan_in  (pixel.red_in),
        .chan_out (result.red_out)
    );

    ppt_channel #(
        .FRAC_BITS      (FRAC_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_green (
        .clk      (clk),
        .cfg      (cfg_reg),
        .chan_in  (pixel.green_in),
        .chan_out (result.green_out)
    );

    ppt_channel #(
        .FRAC_BITS      (FRAC_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_blue (
        .clk      (clk),
        .cfg      (cfg_reg),
        .chan_in  (pixel.blue_in),
        .chan_out (result.blue_out)
    );

    assign result.alpha_out = alpha_reg[PIPE_DEPTH-1];
    assign done             = valid_reg[PIPE_DEPTH-1];

endmodule

FILE: rtl/core/ppt_checker.sv
// Port-level checker for the tone mapper, bound to the top level.
module ppt_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input ppt_pkg::ppt_pixel_in_t  pixel,
    input logic                   done,
    input ppt_pkg::ppt_pixel_out_t result
);
    import ppt_pkg::*;

    // every request gives a result after the fixed latency
    a_req_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##14 done)
        else $error("request without result");

    // no result without a request
    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##14 !done)
        else $error("result without request");

    // alpha passes through unchanged
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.alpha_out == $past(pixel.alpha_in, 14)))
        else $error("alpha altered");

endmodule

bind piecewise_power_tonemap ppt_checker u_ppt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
);

FILE: tb/sv/tb_piecewise_power_tonemap.sv
// Testbench for the piecewise power-curve tone mapper: directed and random pixels.
`timescale 1ns / 1ps

module tb_piecewise_power_tonemap;
    import ppt_pkg::*;

    localparam int FRAC = 16;
    localparam int TBITS = 6;
    localparam int CELLS = 1 << TBITS;
    localparam longint CYCLE_LIMIT = 400000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    ppt_pixel_in_t  pixel;
    logic           done;
    ppt_pixel_out_t result;
    logic           cfg_we;
    logic [2:0]     cfg_index;
    logic [63:0]    cfg_data;

    // Local copy of the register file and the fixed tables
    ppt_cfg_t       cfg_shadow;
    longint         log_cells [0:CELLS];
    longint         pow_cells [0:CELLS];

    // Mapped pixels still awaiting their strobe
    ppt_pixel_out_t mapped_queue [$];

    int             fail_count;
    longint         cycle_count = 0;
    int             send_gap_pct;

    piecewise_power_tonemap DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    // Give up at a generous cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor arithmetic
    // ---------------------------------------------------------------

    // Shift right, rounding toward minus infinity
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint sign_ext21(input logic [20:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem_v;
        logic [63:0] r;
        logic [63:0] b;
        rem_v = v;
        r = 0;
        b = 64'd1 << 62;
        while (b > rem_v)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem_v >= r + b)
            begin
                rem_v = rem_v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Build the log2 and exp2 cells exactly as the curve units hold them
    task automatic build_cells();
        logic [63:0] roots [0:TBITS];
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] prod;
        roots[0] = 64'd2 << 30;
        for (int k = 1; k <= TBITS; k++)
            roots[k] = int_sqrt(roots[k - 1] << 30);
        for (int i = 0; i < CELLS; i++)
        begin
            x = (64'd1 << 30) + (64'(i) << (30 - TBITS));
            r = 0;
            prod = 64'd1 << 30;
            for (int k = 1; k <= 30; k++)
            begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30))
                begin
                    x = x >> 1;
                    r = r | (64'd1 << (30 - k));
                end
            end
            for (int k = 1; k <= TBITS; k++)
                if (((i >> (TBITS - k)) & 1) != 0)
                    prod = (prod * roots[k]) >> 30;
            log_cells[i] = longint'(r);
            pow_cells[i] = longint'(prod);
        end
        log_cells[CELLS] = 64'sd1 << 30;
        pow_cells[CELLS] = 64'sd2 << 30;
    endtask

    // log2 of d at scale 2^(FRAC+16), answered in Q.24
    function automatic longint log2_q24(input logic [63:0] d);
        int          p;
        logic [63:0] f;
        logic [63:0] idx;
        logic [63:0] rem_v;
        logic [63:0] diff;
        longint      interp;
        p = 63;
        while (p > 0 && d[p] == 1'b0)
            p--;
        f = (d << (62 - p)) & ((64'd1 << 62) - 1);
        idx = f >> (62 - TBITS);
        rem_v = (f >> (32 - TBITS)) & ((64'd1 << 30) - 1);
        diff = 64'(log_cells[idx + 1] - log_cells[idx]);
        interp = log_cells[idx] + longint'((diff * rem_v) >> 30);
        return floor_shift(longint'(p - FRAC - 16) * (64'sd1 << 30) + interp, 6);
    endfunction

    // 2^z for z in Q.24, answered in Q.30 and held at 2^53
    function automatic logic [63:0] exp2_q30(input longint z);
        longint      zi;
        logic [63:0] zf;
        logic [63:0] idx;
        logic [63:0] rem_v;
        logic [63:0] mant;
        logic [63:0] diff;
        zi = floor_shift(z, 24);
        zf = 64'(z - zi * (64'sd1 << 24));
        idx = zf >> (24 - TBITS);
        rem_v = zf & ((64'd1 << (24 - TBITS)) - 1);
        diff = 64'(pow_cells[idx + 1] - pow_cells[idx]);
        mant = 64'(pow_cells[idx]) + ((diff * rem_v) >> (24 - TBITS));
        if (zi >= 23)
            return 64'd1 << 53;
        if (zi >= 0)
            return mant << zi;
        if (zi <= -63)
            return 0;
        return mant >> (-zi);
    endfunction

    function automatic logic [17:0] tone_channel(input logic [23:0] x);
        logic [63:0] norm;
        logic [63:0] lo_b;
        logic [63:0] hi_b;
        logic [63:0] curve;
        logic [63:0] place;
        logic [63:0] y;
        logic [63:0] s_mag;
        logic [63:0] mag;
        logic [63:0] cb;
        logic        on_shoulder;
        longint      scale;
        longint      offy;
        longint      d;
        longint      la;
        longint      lg;
        longint      term;
        longint      outv;
        norm = (64'(x) * 64'(cfg_shadow.input_gain)) >> (32 - FRAC);
        lo_b = 64'(cfg_shadow.segment_bounds[15:0]);
        hi_b = 64'(cfg_shadow.segment_bounds[31:16]);
        on_shoulder = 1'b0;
        if ((norm << 16) < (lo_b << FRAC))
        begin
            curve = cfg_shadow.toe_curve;
            place = cfg_shadow.toe_place;
        end
        else if ((norm << 16) < (hi_b << FRAC))
        begin
            curve = cfg_shadow.mid_curve;
            place = cfg_shadow.mid_place;
        end
        else
        begin
            curve = cfg_shadow.shoulder_curve;
            place = cfg_shadow.shoulder_place;
            on_shoulder = 1'b1;
        end
        offy = longint'(place[41:21]);
        scale = sign_ext21(place[62:42]);
        d = longint'(norm << 16) - longint'(64'(place[20:0]) << FRAC);
        if (on_shoulder)
            d = -d;
        y = 0;
        if (d > 0)
        begin
            la = longint'($signed(curve[63:32]));
            cb = 64'(curve[31:0]);
            lg = log2_q24(64'(d));
            y = exp2_q30(la + floor_shift(longint'(cb) * lg, 24));
        end
        s_mag = 64'(scale < 0 ? -scale : scale);
        // Split y so the product stays inside 64 bits; round the magnitude up when negative
        if (scale >= 0)
        begin
            mag = (((y >> 32) * s_mag) << 2) + (((y & 64'hFFFF_FFFF) * s_mag) >> 30);
            term = longint'(mag);
        end
        else
        begin
            mag = (((y >> 32) * s_mag) << 2)
                + (((y & 64'hFFFF_FFFF) * s_mag + ((64'd1 << 30) - 1)) >> 30);
            term = -longint'(mag);
        end
        outv = term + offy;
        if (outv < 0)
            outv = 0;
        if (outv > 262143)
            outv = 262143;
        return 18'(outv);
    endfunction

    function automatic ppt_pixel_out_t tone_pixel(input ppt_pixel_in_t p);
        ppt_pixel_out_t o;
        o.red_out   = tone_channel(p.red_in);
        o.green_out = tone_channel(p.green_in);
        o.blue_out  = tone_channel(p.blue_in);
        o.alpha_out = p.alpha_in;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        fail_count++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
    endtask

    // Compare each strobed result against the oldest mapped pixel
    always @(posedge clk)
    begin
        ppt_pixel_out_t want;
        if (rst_n && done === 1'b1)
        begin
            if (mapped_queue.size() == 0)
                report_mismatch("unexpected result", 24'(result.red_out), 0);
            else
            begin
                want = mapped_queue.pop_front();
                if (result.red_out !== want.red_out)
                    report_mismatch("red_out", 24'(result.red_out), 24'(want.red_out));
                if (result.green_out !== want.green_out)
                    report_mismatch("green_out", 24'(result.green_out), 24'(want.green_out));
                if (result.blue_out !== want.blue_out)
                    report_mismatch("blue_out", 24'(result.blue_out), 24'(want.blue_out));
                if (result.alpha_out !== want.alpha_out)
                    report_mismatch("alpha_out", 24'(result.alpha_out), 24'(want.alpha_out));
            end
        end
    end

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Send one pixel request; hold start across back-to-back requests
    task automatic send_pixel(input ppt_pixel_in_t p);
        while ($urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        mapped_queue.push_back(tone_pixel(p));
    endtask

    // Drop start and wait until every request has come back, plus the pipeline tail
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (mapped_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4)
            @(posedge clk);
    endtask

    // Write one register while the pipeline is empty
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_INPUT_GAIN:     cfg_shadow.input_gain = value[23:0];
            REG_SEGMENT_BOUNDS: cfg_shadow.segment_bounds = value[31:0];
            REG_TOE_CURVE:      cfg_shadow.toe_curve = value;
            REG_TOE_PLACE:      cfg_shadow.toe_place = value;
            REG_MID_CURVE:      cfg_shadow.mid_curve = value;
            REG_MID_PLACE:      cfg_shadow.mid_place = value;
            REG_SHOULDER_CURVE: cfg_shadow.shoulder_curve = value;
            default:            cfg_shadow.shoulder_place = value;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [63:0] make_curve(input int log2_a, input logic [31:0] b);
        return {32'(log2_a), b};
    endfunction

    function automatic logic [63:0] make_place(input logic [20:0] offx, input logic [20:0] offy,
                                               input logic [20:0] scale);
        return {1'b0, scale, offy, offx};
    endfunction

    // A realistic filmic setting: toe, linear mid and shoulder with sensible shapes
    task automatic load_filmic();
        write_reg(REG_INPUT_GAIN, 64'($urandom_range(20000, 140000)));
        write_reg(REG_SEGMENT_BOUNDS, {32'd0, 16'($urandom_range(30000, 60000)),
                                       16'($urandom_range(2000, 25000))});
        write_reg(REG_TOE_CURVE, make_curve(-$urandom_range(0, 1 << 25),
                                             32'($urandom_range(1 << 24, 3 << 24))));
        write_reg(REG_TOE_PLACE, make_place(21'($urandom_range(0, 3000)),
                                            21'($urandom_range(0, 500)),
                                            21'($urandom_range(30000, 90000))));
        write_reg(REG_MID_CURVE, make_curve($urandom_range(0, 1 << 23) - (1 << 22), 32'd1 << 24));
        write_reg(REG_MID_PLACE, make_place(21'($urandom_range(0, 10000)),
                                            21'($urandom_range(0, 20000)),
                                            21'($urandom_range(50000, 80000))));
        write_reg(REG_SHOULDER_CURVE, make_curve(-$urandom_range(0, 1 << 26),
                                                  32'($urandom_range(1 << 23, 3 << 24))));
        write_reg(REG_SHOULDER_PLACE, make_place(21'($urandom_range(70000, 400000)),
                                                 21'($urandom_range(60000, 120000)),
                                                 -21'($urandom_range(30000, 90000))));
    endtask

    // Wholly random registers: any bit may be set
    task automatic load_noise();
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), {$urandom, $urandom});
    endtask

    function automatic logic [23:0] pick_channel();
        case ($urandom_range(9))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2, 3:    return 24'($urandom_range(0, 1 << 20));
            4:       return 24'($urandom);
            default: return 24'($urandom_range(0, 1 << 17));
        endcase
    endfunction

    function automatic ppt_pixel_in_t pick_pixel();
        ppt_pixel_in_t p;
        p.red_in   = pick_channel();
        p.green_in = pick_channel();
        p.blue_in  = pick_channel();
        p.alpha_in = 16'($urandom);
        return p;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset values: unity gain, every segment zero, so every output is the zero offset
    task automatic test_reset_values();
        send_gap_pct = 0;
        send_pixel('{24'd0, 24'hFFFFFF, 24'h010000, 16'hFFFF});
        send_pixel('{24'h123456, 24'd1, 24'h800000, 16'h0000});
        drain();
    endtask

    // Directed corners: non-positive u, huge and tiny exponents, both clamps, crossed bounds
    task automatic test_corners();
        send_gap_pct = 0;
        load_filmic();
        send_pixel('{24'd0, 24'hFFFFFF, 24'h000001, 16'hA5A5});
        send_pixel('{24'h00FFFF, 24'h010000, 24'h7FFFFF, 16'h5A5A});
        drain();
        // Huge exponent, positive then negative scale: saturate both ways
        write_reg(REG_SEGMENT_BOUNDS, 64'd0);
        write_reg(REG_SHOULDER_CURVE, make_curve(30 << 24, 32'd0));
        write_reg(REG_SHOULDER_PLACE, make_place(21'h1FFFFF, 21'd0, 21'h0FFFFF));
        send_pixel('{24'd0, 24'd100, 24'h400000, 16'd1});
        drain();
        write_reg(REG_SHOULDER_PLACE, make_place(21'h1FFFFF, 21'h1FFFFF, 21'h100000));
        send_pixel('{24'd0, 24'd100, 24'h400000, 16'd2});
        drain();
        // Tiny exponent: y falls below one LSB
        write_reg(REG_SHOULDER_CURVE, make_curve(-(80 << 24), 32'd1 << 24));
        send_pixel('{24'd0, 24'd1, 24'h000100, 16'd3});
        drain();
        // Shoulder start below linear start, maximum gain and zero gain
        write_reg(REG_SEGMENT_BOUNDS, {32'd0, 16'h0100, 16'hFF00});
        write_reg(REG_INPUT_GAIN, 64'hFFFFFF);
        write_reg(REG_MID_CURVE, make_curve(0, 32'hFFFFFFFF));
        write_reg(REG_MID_PLACE, make_place(21'd0, 21'h1FFFFF, 21'h1FFFFF));
        send_pixel('{24'h000001, 24'h000100, 24'hFFFFFF, 16'h8000});
        send_pixel('{24'h0000FF, 24'h00FFFF, 24'h00000F, 16'h7FFF});
        drain();
        write_reg(REG_INPUT_GAIN, 64'd0);
        send_pixel('{24'hFFFFFF, 24'h0, 24'h123456, 16'h1234});
        drain();
    endtask

    // Random pixels under several settings and idle phases
    task automatic test_random_pixels();
        int gaps [4] = '{0, 85, 0, 34};
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase % 4 == 3)
                load_noise();
            else
                load_filmic();
            send_gap_pct = gaps[phase % 4];
            for (int n = 0; n < 130; n++)
            begin
                send_pixel(pick_pixel());
                // Hold off until the pipeline has emptied
                if (n == 60 && phase == 2)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (mapped_queue.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        send_gap_pct = 0;
        cfg_shadow = '0;
        cfg_shadow.input_gain = GAIN_RESET;
        build_cells();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_corners();
        test_random_pixels();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
